### hw/rtl/tap_pkg.sv
// shared types and constants of the temperature alarm led pattern unit
package tap_pkg;

   localparam int TempBits    = 12;
   localparam int CounterBits = 13;
   localparam int LenBits     = 13;
   localparam int SegBits     = 3;
   localparam int AddrBits    = 5;
   localparam int DataBits    = 32;

   typedef enum logic [1:0] {
      MODE_NORMAL   = 2'd0,
      MODE_WARNING  = 2'd1,
      MODE_CRITICAL = 2'd2,
      MODE_ERROR    = 2'd3
   } mode_type;

   // register word indexes
   localparam logic [2:0] REG_LOW_THRESHOLD  = 3'd0;
   localparam logic [2:0] REG_HIGH_THRESHOLD = 3'd1;
   localparam logic [2:0] REG_TIMEOUT_TICKS  = 3'd2;
   localparam logic [2:0] REG_SLOW_HALF      = 3'd3;
   localparam logic [2:0] REG_FAST_HALF      = 3'd4;

   localparam logic signed [TempBits-1:0] LowThresholdReset  = TempBits'(480);
   localparam logic signed [TempBits-1:0] HighThresholdReset = TempBits'(560);
   localparam logic [LenBits-1:0] TimeoutReset  = LenBits'(5000);
   localparam logic [LenBits-1:0] SlowHalfReset = LenBits'(1000);
   localparam logic [LenBits-1:0] FastHalfReset = LenBits'(250);

   localparam logic [LenBits-1:0] CritShortTicks = LenBits'(50);
   localparam logic [LenBits-1:0] CritPauseTicks = LenBits'(400);
   localparam logic [LenBits-1:0] ErrBlinkTicks  = LenBits'(100);
   localparam logic [LenBits-1:0] ErrPauseTicks  = LenBits'(500);

   localparam logic [SegBits-1:0] CritLastSeg   = SegBits'(3);
   localparam logic [SegBits-1:0] ErrLastSeg    = SegBits'(6);
   localparam logic [SegBits-1:0] NormalLastSeg = SegBits'(1);

   typedef struct packed {
      logic signed [TempBits-1:0] low_threshold;
      logic signed [TempBits-1:0] high_threshold;
      logic [LenBits-1:0]         timeout_ticks;
      logic [LenBits-1:0]         slow_half_ticks;
      logic [LenBits-1:0]         fast_half_ticks;
   } cfg_type;

endpackage

### hw/rtl/tap_csr.sv
// configuration register bank with apb-style access
module tap_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [tap_pkg::AddrBits-1:0]      paddr,
   input  logic [tap_pkg::DataBits-1:0]      pwdata,
   output logic [tap_pkg::DataBits-1:0]      prdata,
   output logic                              pready,
   output tap_pkg::cfg_type                  cfg
);

   tap_pkg::cfg_type cfg_ff;
   tap_pkg::cfg_type cfg_in;
   logic             wr_en;
   logic [2:0]       reg_idx;

   assign wr_en   = psel && penable && pwrite;
   assign reg_idx = paddr[tap_pkg::AddrBits-1:2];
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            tap_pkg::REG_LOW_THRESHOLD:  cfg_in.low_threshold   = pwdata[tap_pkg::TempBits-1:0];
            tap_pkg::REG_HIGH_THRESHOLD: cfg_in.high_threshold  = pwdata[tap_pkg::TempBits-1:0];
            tap_pkg::REG_TIMEOUT_TICKS:  cfg_in.timeout_ticks   = pwdata[tap_pkg::LenBits-1:0];
            tap_pkg::REG_SLOW_HALF:      cfg_in.slow_half_ticks = pwdata[tap_pkg::LenBits-1:0];
            tap_pkg::REG_FAST_HALF:      cfg_in.fast_half_ticks = pwdata[tap_pkg::LenBits-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         tap_pkg::REG_LOW_THRESHOLD:
            prdata = tap_pkg::DataBits'($unsigned(cfg_ff.low_threshold));
         tap_pkg::REG_HIGH_THRESHOLD:
            prdata = tap_pkg::DataBits'($unsigned(cfg_ff.high_threshold));
         tap_pkg::REG_TIMEOUT_TICKS: prdata = tap_pkg::DataBits'(cfg_ff.timeout_ticks);
         tap_pkg::REG_SLOW_HALF:     prdata = tap_pkg::DataBits'(cfg_ff.slow_half_ticks);
         tap_pkg::REG_FAST_HALF:     prdata = tap_pkg::DataBits'(cfg_ff.fast_half_ticks);
         default:                    prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.low_threshold   <= tap_pkg::LowThresholdReset;
         cfg_ff.high_threshold  <= tap_pkg::HighThresholdReset;
         cfg_ff.timeout_ticks   <= tap_pkg::TimeoutReset;
         cfg_ff.slow_half_ticks <= tap_pkg::SlowHalfReset;
         cfg_ff.fast_half_ticks <= tap_pkg::FastHalfReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### hw/rtl/tap_core.sv
// pattern sequencer: one tick or sample per beat, state registers double as result
module tap_core (
   input  logic                               clock,
   input  logic                               reset,
   input  tap_pkg::cfg_type                   cfg,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_kind,
   input  logic signed [tap_pkg::TempBits-1:0] req_temp_sample,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_led_on,
   output logic [1:0]                         rsp_mode,
   output logic                               rsp_waiting
);

   logic                               rsp_valid_ff, rsp_valid_in;
   logic                               playing_ff, playing_in;
   tap_pkg::mode_type                  mode_ff, mode_in;
   logic [tap_pkg::SegBits-1:0]        seg_ff, seg_in;
   logic [tap_pkg::CounterBits-1:0]    count_ff, count_in;
   logic                               pending_ff, pending_in;
   logic signed [tap_pkg::TempBits-1:0] latest_ff, latest_in;
   logic                               led_ff, led_in;

   logic                               accept;
   logic signed [tap_pkg::TempBits-1:0] class_temp;
   tap_pkg::mode_type                  class_mode;
   logic [tap_pkg::LenBits-1:0]        seg_len;
   logic [tap_pkg::CounterBits-1:0]    count_inc;
   logic                               seg_done;
   logic                               last_seg;
   logic [tap_pkg::SegBits-1:0]        seg_next;

   assign accept      = req_valid && req_ready;
   assign req_ready   = !rsp_valid_ff || rsp_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_led_on  = led_ff;
   assign rsp_mode    = mode_ff;
   assign rsp_waiting = !playing_ff;

   // one classifier serves both a fresh sample and a pending one
   assign class_temp = req_kind ? req_temp_sample : latest_ff;

   always_comb begin
      if (class_temp >= cfg.high_threshold) begin
         class_mode = tap_pkg::MODE_CRITICAL;
      end else if (class_temp >= cfg.low_threshold) begin
         class_mode = tap_pkg::MODE_WARNING;
      end else begin
         class_mode = tap_pkg::MODE_NORMAL;
      end
   end

   always_comb begin
      if (!playing_ff) begin
         seg_len  = cfg.timeout_ticks;
         last_seg = 1'b1;
      end else begin
         case (mode_ff)
            tap_pkg::MODE_NORMAL: begin
               seg_len  = cfg.slow_half_ticks;
               last_seg = (seg_ff == tap_pkg::NormalLastSeg);
            end
            tap_pkg::MODE_WARNING: begin
               seg_len  = cfg.fast_half_ticks;
               last_seg = (seg_ff == tap_pkg::NormalLastSeg);
            end
            tap_pkg::MODE_CRITICAL: begin
               seg_len  = (seg_ff == tap_pkg::CritLastSeg) ? tap_pkg::CritPauseTicks
                                                           : tap_pkg::CritShortTicks;
               last_seg = (seg_ff == tap_pkg::CritLastSeg);
            end
            default: begin
               seg_len  = (seg_ff == tap_pkg::ErrLastSeg) ? tap_pkg::ErrPauseTicks
                                                          : tap_pkg::ErrBlinkTicks;
               last_seg = (seg_ff == tap_pkg::ErrLastSeg);
            end
         endcase
      end
   end

   // saturating tick counter, zero length ends on the first tick
   assign count_inc = (count_ff == '1) ? count_ff : count_ff + 1'b1;
   assign seg_done  = (count_inc >= seg_len);
   assign seg_next  = seg_ff + 1'b1;

   always_comb begin
      playing_in   = playing_ff;
      mode_in      = mode_ff;
      seg_in       = seg_ff;
      count_in     = count_ff;
      pending_in   = pending_ff;
      latest_in    = latest_ff;
      led_in       = led_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (accept) begin
         rsp_valid_in = 1'b1;
         if (req_kind) begin
            latest_in = req_temp_sample;
            if (playing_ff) begin
               pending_in = 1'b1;
            end else begin
               playing_in = 1'b1;
               mode_in    = class_mode;
               seg_in     = '0;
               count_in   = '0;
               led_in     = 1'b1;
            end
         end else begin
            count_in = count_inc;
            if (seg_done) begin
               if (!playing_ff) begin
                  playing_in = 1'b1;
                  mode_in    = tap_pkg::MODE_ERROR;
                  seg_in     = '0;
                  count_in   = '0;
                  led_in     = 1'b1;
               end else if (!last_seg) begin
                  seg_in   = seg_next;
                  count_in = '0;
                  // odd segments are dark, so is the error pause
                  led_in   = !seg_next[0] &&
                             !(mode_ff == tap_pkg::MODE_ERROR && seg_next == tap_pkg::ErrLastSeg);
               end else if (pending_ff) begin
                  pending_in = 1'b0;
                  mode_in    = class_mode;
                  seg_in     = '0;
                  count_in   = '0;
                  led_in     = 1'b1;
               end else begin
                  playing_in = 1'b0;
                  seg_in     = '0;
                  count_in   = '0;
                  led_in     = 1'b0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         playing_ff   <= 1'b0;
         mode_ff      <= tap_pkg::MODE_NORMAL;
         seg_ff       <= '0;
         count_ff     <= '0;
         pending_ff   <= 1'b0;
         led_ff       <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         playing_ff   <= playing_in;
         mode_ff      <= mode_in;
         seg_ff       <= seg_in;
         count_ff     <= count_in;
         pending_ff   <= pending_in;
         led_ff       <= led_in;
      end
   end

   always_ff @(posedge clock) begin
      latest_ff <= latest_in;
   end

endmodule

### hw/rtl/temperature_alarm_led_pattern_unit.sv
// latency: a result beat is valid the cycle after its request beat is taken
// throughput: one tick or sample per cycle unless a held result stalls requests
// the state registers themselves carry the result, so a held result stalls requests
// reset: synchronous, active high; led off, waiting, normal mode, registers at defaults
// user writes configuration registers via apb-style port only while idle; not enforced
module temperature_alarm_led_pattern_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [tap_pkg::AddrBits-1:0]        paddr,
   input  logic [tap_pkg::DataBits-1:0]        pwdata,
   output logic [tap_pkg::DataBits-1:0]        prdata,
   output logic                                pready,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_kind,
   input  logic signed [tap_pkg::TempBits-1:0] req_temp_sample,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_led_on,
   output logic [1:0]                          rsp_mode,
   output logic                                rsp_waiting
);

   tap_pkg::cfg_type cfg;

   tap_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   tap_core u_core (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_kind        (req_kind),
      .req_temp_sample (req_temp_sample),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_led_on      (rsp_led_on),
      .rsp_mode        (rsp_mode),
      .rsp_waiting     (rsp_waiting)
   );

endmodule
